@@ rtl/tcpq_pkg.sv @@
// Shared types and constants for the three-class priority queue.
`default_nettype none

package tcpq_pkg;

  // Default sizing
  localparam int unsigned DEFAULT_CAPACITY = 16;
  localparam int unsigned DEFAULT_TAG_BITS = 16;

  // Operation codes carried in the request tuser
  typedef enum logic [1:0] {
    FUNC_INSERT   = 2'd0,
    FUNC_POP_HEAD = 2'd1,
    FUNC_POP_TAIL = 2'd2,
    FUNC_NOP      = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Priority classes
  localparam logic [1:0] CLASS_TOP    = 2'd0;
  localparam logic [1:0] CLASS_MIDDLE = 2'd1;
  localparam logic [1:0] CLASS_NORMAL = 2'd2;

endpackage

`default_nettype wire

@@ rtl/tcpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcpq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/three_class_priority_queue_top.sv @@
// Three-class strict priority queue built on per-class ring buffers in one RAM.
//
//   Channel   Dir  tvalid/tready handshake   Payload
//   s_axis    in   request                   tuser: func; tdata: order_tag, priority_class
//   m_axis    out  result                    tuser: status; tdata: removed/head/tail, count
//
// Each request passes through S_IDLE, S_REM, S_HEAD and S_TAIL on its way to the
// result register: the update, which also reads the removed entry, then one read of
// the entry RAM each for the head and the tail, all through its single read port.
// A new request is taken only once the sequencer is back in S_IDLE.
// Reset clears the per-class counters and ring pointers; the RAM is not cleared.
// A result waiting on m_axis_tready_i does not block the next request, which
// stalls only in its tail read until the result register frees up.
`default_nettype none

module three_class_priority_queue_top #(
  parameter int unsigned CAPACITY = tcpq_pkg::DEFAULT_CAPACITY,
  parameter int unsigned TAG_BITS = tcpq_pkg::DEFAULT_TAG_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // Request channel
  input  wire logic s_axis_tvalid_i,
  output logic      s_axis_tready_o,
  // tdata: order_tag, priority_class, zero pad
  input  wire logic [((TAG_BITS+2+7)/8)*8-1:0] s_axis_tdata_i,
  // tuser: func
  input  wire logic [1:0] s_axis_tuser_i,
  // Result channel
  output logic      m_axis_tvalid_o,
  input  wire logic m_axis_tready_i,
  // tdata: removed_tag, removed_class, head_tag, head_class, tail_tag, tail_class,
  //        entry_count, zero pad
  output logic [((3*TAG_BITS+6+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata_o,
  // tuser: status
  output logic [1:0] m_axis_tuser_o
);

  import tcpq_pkg::*;

  localparam int unsigned PW     = $clog2(CAPACITY);
  localparam int unsigned CW     = $clog2(CAPACITY+1);
  localparam int unsigned DEPTH  = 3 * (1 << PW);
  localparam int unsigned AW     = PW + 2;
  localparam int unsigned OUT_FW = 3*TAG_BITS + 6 + CW;
  localparam int unsigned OUT_DW = ((OUT_FW+7)/8)*8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM,
    S_HEAD,
    S_TAIL
  } state_e;

  // Ring index (base + off) modulo CAPACITY, with off no larger than CAPACITY
  function automatic logic [PW-1:0] wrap_idx(input logic [PW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[PW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [PW-1:0]     hd_q [3];
  logic [PW-1:0]     hd_d [3];
  logic [CW-1:0]     cnt_q [3];
  logic [CW-1:0]     cnt_d [3];
  logic              rem_flag_q, rem_flag_d;
  status_e           status_q, status_d;
  logic [TAG_BITS-1:0] rem_tag_q, rem_tag_d;
  logic [1:0]        rem_cls_q, rem_cls_d;
  logic [TAG_BITS-1:0] head_tag_q, head_tag_d;
  logic              m_valid_q, m_valid_d;
  logic [OUT_DW-1:0] m_data_q, m_data_d;
  status_e           m_status_q, m_status_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [TAG_BITS-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [TAG_BITS-1:0] ram_rdata;

  logic                in_fire;
  func_e               req_func;
  logic [TAG_BITS-1:0] req_tag;
  logic [1:0]          req_cls_raw;
  logic [1:0]          req_cls;
  logic [CW-1:0]       total;
  logic                q_full;
  logic                q_empty;
  logic [1:0]          head_cls;
  logic [1:0]          tail_cls;
  logic [AW-1:0]       head_addr;
  logic [AW-1:0]       tail_addr;
  logic                out_free;

  tcpq_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Decode the request
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign req_func        = func_e'(s_axis_tuser_i);
  assign req_tag         = s_axis_tdata_i[TAG_BITS-1:0];
  assign req_cls_raw     = s_axis_tdata_i[TAG_BITS+1:TAG_BITS];
  assign req_cls         = (req_cls_raw inside {CLASS_TOP, CLASS_MIDDLE}) ?
                           req_cls_raw : CLASS_NORMAL;

  // Occupancy and the classes that hold the front and back of the queue
  assign total   = CW'(cnt_q[0] + cnt_q[1] + cnt_q[2]);
  assign q_full  = (total == CW'(CAPACITY));
  assign q_empty = (total == '0);

  always_comb begin
    if (cnt_q[CLASS_TOP] != '0) begin
      head_cls = CLASS_TOP;
    end else if (cnt_q[CLASS_MIDDLE] != '0) begin
      head_cls = CLASS_MIDDLE;
    end else begin
      head_cls = CLASS_NORMAL;
    end
    if (cnt_q[CLASS_NORMAL] != '0) begin
      tail_cls = CLASS_NORMAL;
    end else if (cnt_q[CLASS_MIDDLE] != '0) begin
      tail_cls = CLASS_MIDDLE;
    end else begin
      tail_cls = CLASS_TOP;
    end
  end

  assign head_addr = {head_cls, hd_q[head_cls]};
  assign tail_addr = {tail_cls, wrap_idx(hd_q[tail_cls], cnt_q[tail_cls] - CW'(1))};
  assign out_free  = !m_valid_q || m_axis_tready_i;

  // Sequencer: update the rings, then read removed entry, head and tail
  always_comb begin
    state_d    = state_q;
    hd_d       = hd_q;
    cnt_d      = cnt_q;
    rem_flag_d = rem_flag_q;
    status_d   = status_q;
    rem_tag_d  = rem_tag_q;
    rem_cls_d  = rem_cls_q;
    head_tag_d = head_tag_q;
    m_data_d   = m_data_q;
    m_status_d = m_status_q;
    m_valid_d  = m_valid_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = req_tag;
    ram_re     = 1'b0;
    ram_raddr  = '0;

    // Drop the result once taken
    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          status_d   = STATUS_DONE;
          rem_flag_d = 1'b0;
          rem_tag_d  = '0;
          rem_cls_d  = '0;
          state_d    = S_REM;
          case (req_func)
            FUNC_INSERT: begin
              if (q_full) begin
                status_d = STATUS_FULL;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = {req_cls, wrap_idx(hd_q[req_cls], cnt_q[req_cls])};
                cnt_d[req_cls] = cnt_q[req_cls] + CW'(1);
              end
            end
            FUNC_POP_HEAD: begin
              if (q_empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                ram_re          = 1'b1;
                ram_raddr       = head_addr;
                hd_d[head_cls]  = wrap_idx(hd_q[head_cls], CW'(1));
                cnt_d[head_cls] = cnt_q[head_cls] - CW'(1);
                rem_flag_d      = 1'b1;
                rem_cls_d       = head_cls;
              end
            end
            FUNC_POP_TAIL: begin
              if (q_empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                ram_re          = 1'b1;
                ram_raddr       = tail_addr;
                cnt_d[tail_cls] = cnt_q[tail_cls] - CW'(1);
                rem_flag_d      = 1'b1;
                rem_cls_d       = tail_cls;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_REM: begin
        if (rem_flag_q) begin
          rem_tag_d = ram_rdata;
        end
        ram_re    = 1'b1;
        ram_raddr = head_addr;
        state_d   = S_HEAD;
      end
      S_HEAD: begin
        head_tag_d = ram_rdata;
        ram_re     = 1'b1;
        ram_raddr  = tail_addr;
        state_d    = S_TAIL;
      end
      S_TAIL: begin
        // Hold the tail read data until the result register is free
        if (out_free) begin
          if (q_empty) begin
            m_data_d = OUT_DW'({total, 2'b00, {TAG_BITS{1'b0}}, 2'b00,
                                {TAG_BITS{1'b0}}, rem_cls_q, rem_tag_q});
          end else begin
            m_data_d = OUT_DW'({total, tail_cls, ram_rdata, head_cls,
                                head_tag_q, rem_cls_q, rem_tag_q});
          end
          m_status_d = status_q;
          m_valid_d  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      hd_q       <= '{default: '0};
      cnt_q      <= '{default: '0};
      rem_flag_q <= 1'b0;
      status_q   <= STATUS_DONE;
      rem_tag_q  <= '0;
      rem_cls_q  <= '0;
      head_tag_q <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_status_q <= STATUS_DONE;
    end else begin
      state_q    <= state_d;
      hd_q       <= hd_d;
      cnt_q      <= cnt_d;
      rem_flag_q <= rem_flag_d;
      status_q   <= status_d;
      rem_tag_q  <= rem_tag_d;
      rem_cls_q  <= rem_cls_d;
      head_tag_q <= head_tag_d;
      m_valid_q  <= m_valid_d;
      m_data_q   <= m_data_d;
      m_status_q <= m_status_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_status_q;

  // Occupancy never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // An accepted request always moves on to the removal read
  a_fire_to_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_REM)
    else $error("accepted request did not advance");

  // Empty status only with an empty queue
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_status_q == STATUS_EMPTY) |->
      m_data_q[OUT_FW-1 -: CW] == '0)
    else $error("empty status with entries held");

  // Full status only with a full queue
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_status_q == STATUS_FULL) |->
      m_data_q[OUT_FW-1 -: CW] == CW'(CAPACITY))
    else $error("full status without a full queue");

  // No request is taken in the middle of a lookup
  a_rings_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> $stable(total) || $past(state_q) == S_IDLE)
    else $error("counters changed during lookup");

endmodule

`default_nettype wire
